// ===== rtl/isa_pkg.sv =====
// Shared types and constants for the indexed shift array.
package isa_pkg;

  // Fixed field widths of the request and result items.
  localparam int KIND_W    = 3;
  localparam int POS_W     = 4;
  localparam int VALUE_W   = 32;
  localparam int RDATA_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  // Stream data widths, packed fields rounded up to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_READ   = 3'd2,
    KIND_DROP   = 3'd3,
    KIND_ERASE  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Per-cell update command; at most one bit is set in any cycle.
  typedef struct packed {
    logic load;        // take the request word
    logic take_below;  // take the neighbor one index lower (insert shift)
    logic take_above;  // take the neighbor one index higher (erase shift)
  } cell_ctrl_t;

endpackage

// ===== rtl/isa_cell.sv =====
// One storage cell of the shift array: holds one entry and follows its command.
module isa_cell #(
  parameter int DATA_WIDTH = isa_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  isa_pkg::cell_ctrl_t     ctrl,
  input  logic [DATA_WIDTH-1:0]   load_data,
  input  logic [DATA_WIDTH-1:0]   below_data,
  input  logic [DATA_WIDTH-1:0]   above_data,
  output logic [DATA_WIDTH-1:0]   data_q
);
  import isa_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    priority if (ctrl.load) begin
      data_nxt = load_data;
    end else if (ctrl.take_below) begin
      data_nxt = below_data;
    end else if (ctrl.take_above) begin
      data_nxt = above_data;
    end else begin
      data_nxt = data_r;
    end
  end

  // Payload only, so no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== rtl/indexed_shift_array.sv =====
// Top level of the indexed shift array: request decode, cell row and result register.
// Output: each result is registered, shown in the cycle after its request is accepted.
// Throughput: one request per cycle while results drain; the whole row of cells shifts
// up or down together as a request is accepted, so no request waits on another.
// Reset: synchronous, active low; the count and the output valid clear at once, while
// the cell contents stay undefined until written and are never read before that.
module indexed_shift_array #(
  parameter int DEPTH      = isa_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = isa_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request items.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: kind[2:0], position[6:3], value[38:7], zero pad[39].
  input  logic [isa_pkg::IN_TDATA_W-1:0] in_tdata,
  // Result items.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: read_data[31:0], status[33:32], count[38:34], zero pad[39].
  output logic [isa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import isa_pkg::*;

  // The count must hold DEPTH itself; comparisons run at the wider of the count
  // and the position field so no bits are lost either way.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request fields.
  kind_t                 kind;
  logic [POS_W-1:0]      position;
  logic [VALUE_W-1:0]    value;
  logic                  in_accept;

  assign kind      = kind_t'(in_tdata[KIND_W-1:0]);
  assign position  = in_tdata[KIND_W +: POS_W];
  assign value     = in_tdata[KIND_W+POS_W +: VALUE_W];

  // The request word is sign-extended to the storage width or truncated to it.
  logic [DATA_WIDTH-1:0] word;
  generate
    if (DATA_WIDTH > VALUE_W) begin : g_word_ext
      assign word = {{(DATA_WIDTH-VALUE_W){value[VALUE_W-1]}}, value};
    end else begin : g_word_trunc
      assign word = value[DATA_WIDTH-1:0];
    end
  endgenerate

  // Fill count.
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;

  assign cnt_ext = CMP_W'(count_r);
  assign pos_ext = CMP_W'(position);

  logic is_full;
  logic is_empty;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // Request decode: which operation succeeds, and the status it reports.
  logic    app_ok;
  logic    ins_ok;
  logic    rd_ok;
  logic    drop_ok;
  logic    ers_ok;
  status_t status;

  always_comb begin
    app_ok  = 1'b0;
    ins_ok  = 1'b0;
    rd_ok   = 1'b0;
    drop_ok = 1'b0;
    ers_ok  = 1'b0;
    status  = ST_OK;
    unique case (kind)
      KIND_APPEND: begin
        if (is_full) status = ST_FULL;
        else         app_ok = 1'b1;
      end
      KIND_INSERT: begin
        // A full list is reported before a bad position.
        if (is_full)                status = ST_FULL;
        else if (pos_ext > cnt_ext) status = ST_RANGE;
        else                        ins_ok = 1'b1;
      end
      KIND_READ: begin
        if (pos_ext >= cnt_ext) status = ST_RANGE;
        else                    rd_ok  = 1'b1;
      end
      KIND_DROP: begin
        if (is_empty) status  = ST_EMPTY;
        else          drop_ok = 1'b1;
      end
      KIND_ERASE: begin
        if (pos_ext >= cnt_ext) status = ST_RANGE;
        else                    ers_ok = 1'b1;
      end
      default: begin
        // Unused codes leave everything as it is and report success.
      end
    endcase
  end

  // The output register frees up whenever the current result is taken, so a new
  // request can enter in the same cycle.
  logic out_valid_r;
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    count_nxt = count_r;
    if (in_accept) begin
      if (app_ok || ins_ok) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (drop_ok || ers_ok) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // Row of cells. Each cell decides from its own index whether it loads the new
  // word, takes its lower neighbor (insert opens a gap at the position), or takes
  // its upper neighbor (erase closes the gap left at the position).
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
      cell_ctrl_t            ctrl;
      logic [DATA_WIDTH-1:0] below;
      logic [DATA_WIDTH-1:0] above;

      assign ctrl.load       = in_accept &&
                               ((app_ok && (IDX == cnt_ext)) ||
                                (ins_ok && (IDX == pos_ext)));
      assign ctrl.take_below = in_accept && ins_ok &&
                               (IDX > pos_ext) && (IDX <= cnt_ext);
      assign ctrl.take_above = in_accept && ers_ok &&
                               (IDX >= pos_ext) && ((IDX + CMP_W'(1)) < cnt_ext);

      // The end cells never shift in from beyond the row; tie those inputs off.
      if (i == 0) begin : g_first
        assign below = word;
      end else begin : g_below
        assign below = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign above = word;
      end else begin : g_above
        assign above = cell_q[i+1];
      end

      isa_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .load_data  (word),
        .below_data (below),
        .above_data (above),
        .data_q     (cell_q[i])
      );
    end
  endgenerate

  // Read path: one entry selected by the position, sign-extended or truncated
  // to the result width. A position outside the row only occurs with a range
  // error, whose result does not use this value.
  logic [DATA_WIDTH-1:0] rd_entry;
  logic [RDATA_W-1:0]    rd_ext;
  logic [RDATA_W-1:0]    read_data;

  assign rd_entry = cell_q[IDX_W'(position)];

  generate
    if (DATA_WIDTH >= RDATA_W) begin : g_rd_trunc
      assign rd_ext = rd_entry[RDATA_W-1:0];
    end else begin : g_rd_ext
      assign rd_ext = {{(RDATA_W-DATA_WIDTH){rd_entry[DATA_WIDTH-1]}}, rd_entry};
    end
  endgenerate

  // Refused requests answer all ones; successful reads answer the entry; the rest zero.
  always_comb begin
    if (status != ST_OK) begin
      read_data = '1;
    end else if (rd_ok) begin
      read_data = rd_ext;
    end else begin
      read_data = '0;
    end
  end

  // Result register.
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {1'b0, COUNT_W'(count_nxt), status, read_data};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== dv/indexed_shift_array_test.sv =====
// Self-checking testbench for the indexed shift array: directed, fill and drain, random traffic.
`timescale 1ns / 100ps

module indexed_shift_array_test;
  import isa_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;

  // Request kinds that the block does not decode; they must leave the list alone.
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

  // One result item as the block returns it.
  typedef struct {
    logic [RDATA_W-1:0]  rdata;
    status_t             status;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Idle percentages for the two sides; changed per test phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Shadow copy of the list, updated at every accepted request item.
  logic [VALUE_W-1:0] list_words [LIST_DEPTH];
  int                 list_fill = 0;

  // Results still owed by the block, oldest first.
  list_result_t expected_results [$];
  int           mismatch_count = 0;
  int           result_index   = 0;

  indexed_shift_array dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Receiver: out_tready is redrawn every cycle from the current stall rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [RDATA_W-1:0] got,
                                 input logic [RDATA_W-1:0] want);
    mismatch_count++;
    $display("mismatch: result %0d %s: got %0h, expected %0h at %0t ns",
             result_index, what, got, want, $time);
  endtask

  // Apply one accepted request to the shadow list and queue the result it must produce.
  // Refusals leave the list untouched and return all ones as read data.
  task automatic predict_list_result(input logic [KIND_W-1:0] kind,
                                     input logic [POS_W-1:0] pos,
                                     input logic [VALUE_W-1:0] value);
    list_result_t r;
    int           i;
    r.rdata  = '0;
    r.status = ST_OK;
    case (kind)
      KIND_APPEND: begin
        if (list_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_fill] = value;
          list_fill++;
        end
      end
      KIND_INSERT: begin
        // The full check wins over the position check.
        if (list_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (pos > list_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = list_fill; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = value;
          list_fill++;
        end
      end
      KIND_READ: begin
        if (pos >= list_fill) r.status = ST_RANGE;
        else r.rdata = list_words[pos];
      end
      KIND_DROP: begin
        if (list_fill == 0) r.status = ST_EMPTY;
        else list_fill--;
      end
      KIND_ERASE: begin
        if (pos >= list_fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = pos + 1; i < list_fill; i++) list_words[i-1] = list_words[i];
          list_fill--;
        end
      end
      default: ;
    endcase
    if (r.status != ST_OK) r.rdata = '1;
    r.count = list_fill[COUNT_W-1:0];
    expected_results.insert(expected_results.size(), r);
  endtask

  // Offer one request item, idling first at the current sender rate, and return right
  // after the edge that accepts it. in_tvalid stays high so a following item can go
  // back to back; whoever idles next lowers it.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, value, pos, kind};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predict_list_result(kind, pos, value);
  endtask

  // Words weighted toward the sign extremes, all ones and zero.
  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Result checker: each accepted result item is matched against the oldest expectation.
  always @(posedge clk) begin
    list_result_t want;
    if (out_tvalid === 1'b1 && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("with none expected", out_tdata[RDATA_W-1:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.rdata)
          report_mismatch("read_data", out_tdata[31:0], want.rdata);
        if (out_tdata[33:32] !== want.status)
          report_mismatch("status", RDATA_W'(out_tdata[33:32]), RDATA_W'(want.status));
        if (out_tdata[38:34] !== want.count)
          report_mismatch("count", RDATA_W'(out_tdata[38:34]), RDATA_W'(want.count));
      end
      result_index++;
    end
  end

  // Every kind once, refusals on an empty list, the sign extremes of the data word,
  // insert at the count (acts as an append), insert and erase in the middle, and the
  // unused kind codes.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(KIND_DROP,   4'd0,  '0);            // drop on an empty list
    send_request(KIND_READ,   4'd0,  '0);            // read on an empty list
    send_request(KIND_ERASE,  4'd15, '0);            // erase on an empty list
    send_request(KIND_INSERT, 4'd1,  32'h1234_5678); // insert past the count
    send_request(KIND_UNUSED_FIRST, 4'd3, 32'hdead_beef);
    send_request(KIND_UNUSED_LAST,  4'd0, '1);
    send_request(KIND_INSERT, 4'd0,  32'h8000_0000);
    send_request(KIND_APPEND, 4'd9,  32'h7fff_ffff);
    send_request(KIND_INSERT, 4'd2,  '0);            // insert at the count
    send_request(KIND_INSERT, 4'd1,  '1);            // shifts two entries up
    send_request(KIND_READ,   4'd0,  '0);
    send_request(KIND_READ,   4'd1,  '0);
    send_request(KIND_READ,   4'd2,  '0);
    send_request(KIND_READ,   4'd3,  '0);
    send_request(KIND_READ,   4'd4,  '0);            // one past the last entry
    send_request(KIND_ERASE,  4'd1,  '0);            // shifts two entries down
    send_request(KIND_READ,   4'd1,  '0);
    send_request(KIND_INSERT, 4'd4,  32'h5555_aaaa); // beyond the count of three
    send_request(KIND_ERASE,  4'd2,  '0);            // erase the last entry
    send_request(KIND_DROP,   4'd15, 32'hffff_0000);
    send_request(KIND_UNUSED_FIRST + 3'd1, 4'd15, '0);
    send_request(KIND_READ,   4'd15, '0);
    send_request(KIND_DROP,   4'd0,  '0);            // list is empty again
  endtask

  // Fill to the full depth, try both growing kinds on the full list, read every
  // entry, then empty the list by erases and drops.
  task automatic test_fill_and_drain();
    int i;
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    while (list_fill < LIST_DEPTH) begin
      send_request($urandom_range(1) ? KIND_INSERT : KIND_APPEND,
                   POS_W'($urandom_range(list_fill)), random_word());
    end
    send_request(KIND_APPEND, POS_W'($urandom_range(15)), random_word());
    send_request(KIND_INSERT, POS_W'($urandom_range(15)), random_word());
    for (i = 0; i < LIST_DEPTH; i++) send_request(KIND_READ, POS_W'(i), '0);
    send_request(KIND_ERASE, 4'd15, '0);
    send_request(KIND_ERASE, 4'd0,  '0);
    while (list_fill > 0) begin
      if ($urandom_range(1))
        send_request(KIND_DROP, POS_W'($urandom_range(15)), random_word());
      else
        send_request(KIND_ERASE, POS_W'($urandom_range(list_fill - 1)), random_word());
    end
    send_request(KIND_DROP, 4'd0, '0);
  endtask

  // Random requests under each idle setting. The growth bias swings every 30 items so
  // the list repeatedly runs from empty to full and back; most positions fall inside
  // the list, a tenth anywhere.
  task automatic test_random_traffic(input int items_per_phase);
    int send_pcts [4] = '{0, 74, 0, 15};
    int recv_pcts [4] = '{0, 0, 74, 15};
    int grow_pcts [3] = '{85, 50, 15};
    int phase;
    int n;
    int grow_pct;
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos;
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = recv_pcts[phase];
      for (n = 0; n < items_per_phase; n++) begin
        grow_pct = grow_pcts[(n / 30) % 3];
        pos      = POS_W'($urandom_range(15));
        if ($urandom_range(99) < 3) begin
          kind = KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
        end else if ($urandom_range(99) < grow_pct) begin
          kind = $urandom_range(1) ? KIND_INSERT : KIND_APPEND;
          if ($urandom_range(9) != 0)
            pos = POS_W'($urandom_range(list_fill < 15 ? list_fill : 15));
        end else begin
          case ($urandom_range(4))
            0, 1:    kind = KIND_READ;
            2:       kind = KIND_DROP;
            default: kind = KIND_ERASE;
          endcase
          if (list_fill != 0 && $urandom_range(9) != 0)
            pos = POS_W'($urandom_range(list_fill - 1));
        end
        send_request(kind, pos, random_word());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_random_traffic(320);

    in_tvalid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    // Results are registered in the block; the edges that follow catch any stray result.
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // The watchdog below lies far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== indexed_shift_array.f =====
rtl/isa_pkg.sv
rtl/isa_cell.sv
rtl/indexed_shift_array.sv
dv/indexed_shift_array_test.sv
